/* src/spi_frame_master_crc8_macros.svh */
// Assertion helpers shared by the SPI frame master RTL.
// Uses the clk and rst names of the including module.
`ifndef SPI_FRAME_MASTER_CRC8_MACROS_SVH
`define SPI_FRAME_MASTER_CRC8_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPIFM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spi frame master assertion failed");

// Next-cycle implication, disabled during reset.
`define SPIFM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spi frame master assertion failed");

`endif

/* src/spifm_pkg.sv */
`timescale 1ns / 1ps
// Types, constants and CRC helpers for the SPI frame master.
// No dependencies; used by spifm_out_fifo and spi_frame_master_crc8.
package spifm_pkg;

  localparam int FRAME_BITS = 32;
  localparam int BIT_POS_W = $clog2(FRAME_BITS);
  localparam int BIT_CNT_W = BIT_POS_W + 1;
  localparam int TICK_W = 16;
  localparam int CMD_W = 24;
  localparam logic [7:0] CRC_POLY = 8'h1D;
  localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 16'd5;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef struct packed {
    logic                  clock_line;
    logic                  tx_line;
    logic                  busy_res;
    logic                  frame_done;
    logic [FRAME_BITS-1:0] rx_word;
  } result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Frame: low byte, middle byte, high byte, then CRC over those three.
  function automatic logic [FRAME_BITS-1:0] frame_build(input logic [CMD_W-1:0] cmd);
    logic [7:0] crc;
    crc = crc8_byte(crc8_byte(crc8_byte(8'h00, cmd[7:0]), cmd[15:8]), cmd[23:16]);
    return {cmd[7:0], cmd[15:8], cmd[23:16], crc};
  endfunction

endpackage

/* src/spifm_out_fifo.sv */
`timescale 1ns / 1ps
// Two-entry result buffer between the frame engine and the output channel.
// Depends on spifm_pkg for result_t.
`include "spi_frame_master_crc8_macros.svh"

module spifm_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spifm_pkg::result_t push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output spifm_pkg::result_t out_data
);
  import spifm_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign pop = out_valid && !out_stall;
  assign room = (count != 2'd2) || pop;
  assign out_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `SPIFM_ASSERT_NOW(a_count_bound, 1'b1, count <= 2'd2)
  `SPIFM_ASSERT_NOW(a_no_overflow, push && (count == 2'd2), pop)

endmodule

/* src/spi_frame_master_crc8.sv */
`timescale 1ns / 1ps
// SPI frame master, mode 0, MSB first, 32-bit frame with CRC-8 (poly 0x1D).
// Input request channel: in_valid / in_stall with op, command, rx_line.
//   op = start takes a 24-bit command and begins a frame (ignored when busy);
//   op = tick advances bit timing by one tick and samples rx_line.
// Output channel: out_valid / out_stall, one result per request carrying
//   clock_line, tx_line, busy_res, frame_done and rx_word.
// Config channel: cfg_valid / cfg_ready / cfg_data sets half_period_ticks
//   (ticks the clock stays high, and again low); cfg_ready is always high.
//   Write it only while no request is in flight.
// A request waits in the input register and its result in the result buffer.
// Throughput: one request per cycle unless in_stall is high; the frame state
//   updates in a single pass of logic behind the input register.
// A two-entry result buffer keeps requests flowing while one result waits;
//   in_stall rises only when both entries are held by a stalled receiver.
// Reset: idle, clock low, tx low, rx_word zero, half period 5 ticks.
`include "spi_frame_master_crc8_macros.svh"

module spi_frame_master_crc8 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            op,
  input  logic [spifm_pkg::CMD_W-1:0]     command,
  input  logic                            rx_line,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            clock_line,
  output logic                            tx_line,
  output logic                            busy_res,
  output logic                            frame_done,
  output logic [spifm_pkg::FRAME_BITS-1:0] rx_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spifm_pkg::TICK_W-1:0]    cfg_data
);
  import spifm_pkg::*;

  // config
  logic [TICK_W-1:0] half_period_ticks;

  // input register
  logic                  s1_valid;
  op_t                   s1_op;
  logic                  s1_rx;
  logic [FRAME_BITS-1:0] s1_frame;

  // frame state
  logic [FRAME_BITS-1:0] tx_shift, tx_shift_next;
  logic [FRAME_BITS-1:0] rx_shift, rx_shift_next;
  logic [BIT_CNT_W-1:0]  bit_index, bit_index_next;
  logic                  clock_phase_high, clock_phase_high_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic                  active, active_next;
  logic                  data_out, data_out_next;

  logic                  done;
  logic [TICK_W-1:0]     limit;
  logic [BIT_POS_W-1:0]  pos;
  logic [BIT_POS_W-1:0]  next_pos;
  logic [BIT_CNT_W-1:0]  bit_inc;
  logic [TICK_W-1:0]     tick_inc;

  logic    in_fire;
  logic    s1_adv;
  logic    fifo_room;
  result_t res;
  result_t out_data;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && fifo_room;
  assign in_stall  = s1_valid && !fifo_room;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_period_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Frame and CRC are built on the way into the input register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op    <= op_t'(op);
      s1_rx    <= rx_line;
      s1_frame <= frame_build(command);
    end
  end

  always_comb begin
    tx_shift_next         = tx_shift;
    rx_shift_next         = rx_shift;
    bit_index_next        = bit_index;
    clock_phase_high_next = clock_phase_high;
    tick_count_next       = tick_count;
    active_next           = active;
    data_out_next         = data_out;
    done                  = 1'b0;

    limit    = (half_period_ticks == '0) ? TICK_W'(1) : half_period_ticks;
    pos      = BIT_POS_W'(FRAME_BITS - 1) - bit_index[BIT_POS_W-1:0];
    bit_inc  = bit_index + BIT_CNT_W'(1);
    next_pos = BIT_POS_W'(FRAME_BITS - 1) - bit_inc[BIT_POS_W-1:0];
    tick_inc = tick_count + TICK_W'(1);

    if (s1_adv) begin
      case (s1_op)
        OP_START: begin
          if (!active) begin
            tx_shift_next         = s1_frame;
            rx_shift_next         = '0;
            bit_index_next        = '0;
            active_next           = 1'b1;
            data_out_next         = s1_frame[FRAME_BITS-1];
            clock_phase_high_next = 1'b1;
            tick_count_next       = '0;
          end
        end
        OP_TICK: begin
          if (active) begin
            tick_count_next = tick_inc;
            if (tick_inc >= limit) begin
              tick_count_next = '0;
              if (clock_phase_high) begin
                clock_phase_high_next = 1'b0;
              end else begin
                // sample on the end of the low phase, then move to the next bit
                rx_shift_next[pos] = s1_rx;
                bit_index_next     = bit_inc;
                if (bit_inc >= BIT_CNT_W'(FRAME_BITS)) begin
                  active_next = 1'b0;
                  done        = 1'b1;
                end else begin
                  data_out_next         = tx_shift[next_pos];
                  clock_phase_high_next = 1'b1;
                end
              end
            end
          end
        end
        default: begin
          active_next = active;
        end
      endcase
    end

    res.clock_line = clock_phase_high_next;
    res.tx_line    = data_out_next;
    res.busy_res   = active_next;
    res.frame_done = done;
    res.rx_word    = rx_shift_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift         <= '0;
      rx_shift         <= '0;
      bit_index        <= '0;
      clock_phase_high <= 1'b0;
      tick_count       <= '0;
      active           <= 1'b0;
      data_out         <= 1'b0;
    end else begin
      tx_shift         <= tx_shift_next;
      rx_shift         <= rx_shift_next;
      bit_index        <= bit_index_next;
      clock_phase_high <= clock_phase_high_next;
      tick_count       <= tick_count_next;
      active           <= active_next;
      data_out         <= data_out_next;
    end
  end

  spifm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_adv),
    .push_data (res),
    .room      (fifo_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign clock_line = out_data.clock_line;
  assign tx_line    = out_data.tx_line;
  assign busy_res   = out_data.busy_res;
  assign frame_done = out_data.frame_done;
  assign rx_word    = out_data.rx_word;

  `SPIFM_ASSERT_NEXT(a_done_goes_idle, s1_adv && done, !active)
  `SPIFM_ASSERT_NOW(a_bit_index_bound, active, bit_index < BIT_CNT_W'(FRAME_BITS))
  `SPIFM_ASSERT_NEXT(a_hold_when_parked, !s1_adv, $stable(rx_shift) && $stable(bit_index))

endmodule

/* sim/tb_spi_frame_master_crc8.sv */
`timescale 1ns / 1ps
// Self-checking testbench for spi_frame_master_crc8: queued start/tick requests,
// a per-request frame predictor, and random idling on both channels.
// Depends on spifm_pkg and the spi_frame_master_crc8 RTL.
module tb_spi_frame_master_crc8;
  import spifm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_PRINTS = 20;

  typedef struct {
    op_t              op;
    logic [CMD_W-1:0] cmd;
    logic             rx;
    bit               hold;
  } spi_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  op = OP_TICK;
  logic [CMD_W-1:0]      command = '0;
  logic                  rx_line = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  clock_line;
  logic                  tx_line;
  logic                  busy_res;
  logic                  frame_done;
  logic [FRAME_BITS-1:0] rx_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [TICK_W-1:0]     cfg_data = '0;

  spi_frame_master_crc8 u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .command    (command),
    .rx_line    (rx_line),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .clock_line (clock_line),
    .tx_line    (tx_line),
    .busy_res   (busy_res),
    .frame_done (frame_done),
    .rx_word    (rx_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  spi_req_t pending_reqs[$];
  result_t  expected_results[$];

  int n_added = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_errors = 0;
  int n_frames = 0;
  int n_cfg = 0;
  int n_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Predicted frame engine state.
  logic [TICK_W-1:0]     half_ticks = HALF_PERIOD_RESET;
  logic [FRAME_BITS-1:0] fm_tx_frame = '0;
  logic [FRAME_BITS-1:0] fm_rx_word = '0;
  logic [5:0]            fm_bit_cnt = '0;
  logic                  fm_clk_high = 1'b0;
  logic [TICK_W-1:0]     fm_ticks = '0;
  logic                  fm_busy = 1'b0;
  logic                  fm_data = 1'b0;

  // CRC-8, poly 0x1D, fed one bit at a time, first byte's MSB first.
  function automatic logic [7:0] crc8_stream(input logic [23:0] bits);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 23; i >= 0; i--) begin
      if (c[7] ^ bits[i]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  task automatic predict_frame(input op_t f_op, input logic [CMD_W-1:0] f_cmd,
                               input logic f_rx, output result_t r);
    logic [TICK_W-1:0] lim;
    logic done;
    done = 1'b0;
    lim = (half_ticks == 0) ? 16'd1 : half_ticks;
    if (f_op == OP_START) begin
      if (!fm_busy) begin
        fm_tx_frame = {f_cmd[7:0], f_cmd[15:8], f_cmd[23:16], 8'h00};
        fm_tx_frame[7:0] = crc8_stream(fm_tx_frame[31:8]);
        fm_rx_word = '0;
        fm_bit_cnt = '0;
        fm_busy = 1'b1;
        fm_data = fm_tx_frame[31];
        fm_clk_high = 1'b1;
        fm_ticks = '0;
      end
    end else if (fm_busy) begin
      fm_ticks = fm_ticks + 16'd1;
      if (fm_ticks >= lim) begin
        fm_ticks = '0;
        if (fm_clk_high) begin
          fm_clk_high = 1'b0;
        end else begin
          // sample on the last low tick, then move to the next bit
          fm_rx_word[31 - fm_bit_cnt[4:0]] = f_rx;
          fm_bit_cnt = fm_bit_cnt + 6'd1;
          if (fm_bit_cnt >= FRAME_BITS) begin
            fm_busy = 1'b0;
            done = 1'b1;
          end else begin
            fm_data = fm_tx_frame[31 - fm_bit_cnt[4:0]];
            fm_clk_high = 1'b1;
          end
        end
      end
    end
    r.clock_line = fm_clk_high;
    r.tx_line = fm_data;
    r.busy_res = fm_busy;
    r.frame_done = done;
    r.rx_word = fm_rx_word;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_errors < MAX_PRINTS)
      $display("MISMATCH result %0d %s: got %h, want %h", n_recv, field, got, want);
    n_errors++;
  endtask

  // Driver: present queued requests, predict each one as it is accepted.
  always @(posedge clk) begin : drive_proc
    logic take;
    logic fire;
    spi_req_t nx;
    result_t r;
    take = in_valid && !in_stall;
    fire = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (take) begin
        predict_frame(op_t'(op), command, rx_line, r);
        expected_results.push_back(r);
        n_sent <= n_sent + 1;
      end
      if (!in_valid || take) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          // hold a marked request until every earlier result is back
          if (!pending_reqs[0].hold || n_recv == n_sent + (take ? 1 : 0)) fire = 1'b1;
        end
        if (fire) begin
          nx = pending_reqs.pop_front();
          in_valid <= 1'b1;
          op <= nx.op;
          command <= nx.cmd;
          rx_line <= nx.rx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_proc
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      n_recv <= n_recv + 1;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request", rx_word, '0);
      end else begin
        want = expected_results.pop_front();
        if (clock_line !== want.clock_line)
          report_mismatch("clock_line", 32'(clock_line), 32'(want.clock_line));
        if (tx_line !== want.tx_line)
          report_mismatch("tx_line", 32'(tx_line), 32'(want.tx_line));
        if (busy_res !== want.busy_res)
          report_mismatch("busy_res", 32'(busy_res), 32'(want.busy_res));
        if (frame_done !== want.frame_done)
          report_mismatch("frame_done", 32'(frame_done), 32'(want.frame_done));
        if (rx_word !== want.rx_word) report_mismatch("rx_word", rx_word, want.rx_word);
        if (want.frame_done) n_frames++;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d results", n_cycles, n_recv, n_added);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_req(input op_t r_op, input logic [CMD_W-1:0] r_cmd,
                         input logic r_rx, input bit r_hold);
    spi_req_t q;
    q.op = r_op;
    q.cmd = r_cmd;
    q.rx = r_rx;
    q.hold = r_hold;
    pending_reqs.push_back(q);
    n_added++;
  endtask

  // One start followed by enough ticks for a whole frame; sometimes cut short,
  // with stray starts mid-frame and stray ticks while idle.
  task automatic add_frame(input int h);
    int lim;
    int nt;
    logic [CMD_W-1:0] cmd;
    lim = (h == 0) ? 1 : h;
    case ($urandom_range(7))
      0: cmd = 24'h000000;
      1: cmd = 24'hFFFFFF;
      default: cmd = 24'($urandom);
    endcase
    if ($urandom_range(9) == 0) add_req(OP_TICK, 24'($urandom), 1'($urandom), 1'b0);
    add_req(OP_START, cmd, 1'($urandom), 1'b0);
    nt = 2 * FRAME_BITS * lim + $urandom_range(2);
    if ($urandom_range(7) == 0) nt = $urandom_range(1, 2 * FRAME_BITS * lim);
    for (int i = 0; i < nt; i++) begin
      if ($urandom_range(39) == 0) add_req(OP_START, 24'($urandom), 1'($urandom), 1'b0);
      add_req(OP_TICK, 24'($urandom), 1'($urandom), $urandom_range(63) == 0);
    end
  endtask

  // Drain every request in flight, then write the half period.
  task automatic write_half_period(input logic [TICK_W-1:0] v);
    while (n_recv != n_added) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    half_ticks = v;
    n_cfg++;
  endtask

  task automatic run_phase(input int sp, input int rp, input logic [TICK_W-1:0] h,
                           input int target);
    int first;
    write_half_period(h);
    send_idle_pct = sp;
    recv_stall_pct = rp;
    first = n_added;
    while (n_added - first < target) add_frame(h);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: ticks while idle, extreme commands, a start while busy.
    add_req(OP_TICK, 24'hFFFFFF, 1'b1, 1'b0);
    add_req(OP_TICK, 24'h000000, 1'b0, 1'b0);
    add_req(OP_START, 24'hFFFFFF, 1'b1, 1'b0);
    add_req(OP_START, 24'h000000, 1'b0, 1'b0);
    for (int i = 0; i < 20; i++) add_req(OP_TICK, 24'($urandom), i[0], i == 10);

    // Longest half period while the directed frame is still running.
    write_half_period(16'hFFFF);
    for (int i = 0; i < 40; i++) add_req(OP_TICK, 24'($urandom), 1'($urandom), 1'b0);

    // Shrink the half period below the tick count already spent.
    run_phase(0, 0, 16'd1, 100);
    run_phase(54, 0, 16'd0, 60);
    run_phase(0, 54, 16'd2, 100);
    run_phase(11, 11, 16'd1, 100);

    while (n_recv != n_added) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never returned", expected_results.size(), '0);

    $display("Covered %0d requests and %0d results, %0d completed frames, %0d writes of %s",
             n_added, n_recv, n_frames, n_cfg, "half_period_ticks from 0 to 65535");
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
